// File: rtl/core/srq_pkg.sv
// ----------------------------------------------------------------------------
// srq_pkg
// Shared types, register codes and helper functions of the sample
// requantizer with error feedback.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srq_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int SAMPLE_W      = 32;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int CODE_W        = 16;
    localparam int INT_W         = 17;
    localparam int MODE_W        = 3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_FORMAT = 2'd0;
    localparam cfg_idx_t CFG_OFFSET = 2'd1;
    localparam cfg_idx_t CFG_GAIN   = 2'd2;

    typedef logic [MODE_W-1:0] fmt_t;

    localparam fmt_t FMT_UINT8  = 3'd0;
    localparam fmt_t FMT_INT8   = 3'd1;
    localparam fmt_t FMT_UINT16 = 3'd2;
    localparam fmt_t FMT_INT16  = 3'd3;
    localparam fmt_t FMT_MULAW  = 3'd4;

    localparam fmt_t                   FMT_RESET    = FMT_INT16;
    localparam logic [CFG_DATA_W-1:0]  OFFSET_RESET = 32'd0;
    localparam logic [CFG_DATA_W-1:0]  GAIN_RESET   = 32'd65536;

    localparam logic signed [INT_W-1:0] BOUND_U8_HI  = 17'sd255;
    localparam logic signed [INT_W-1:0] BOUND_S8_LO  = -17'sd128;
    localparam logic signed [INT_W-1:0] BOUND_S8_HI  = 17'sd127;
    localparam logic signed [INT_W-1:0] BOUND_U16_HI = 17'sd65535;
    localparam logic signed [INT_W-1:0] BOUND_S16_LO = -17'sd32768;
    localparam logic signed [INT_W-1:0] BOUND_S16_HI = 17'sd32767;
    localparam logic signed [INT_W-1:0] BOUND_ZERO   = 17'sd0;

    localparam logic [14:0] MULAW_CLIP = 15'd32635;
    localparam logic [15:0] MULAW_BIAS = 16'd132;

    typedef struct packed {
        logic signed [INT_W-1:0] lo;
        logic signed [INT_W-1:0] hi;
        logic                    mulaw;
        logic                    narrow;
    } fmt_ctl_t;

    function automatic fmt_ctl_t fmt_decode(fmt_t mode);
        fmt_ctl_t c;
        c.mulaw  = (mode == FMT_MULAW);
        c.narrow = (mode == FMT_UINT8) || (mode == FMT_INT8);
        case (mode)
            FMT_UINT8:
            begin
                c.lo = BOUND_ZERO;
                c.hi = BOUND_U8_HI;
            end
            FMT_INT8:
            begin
                c.lo = BOUND_S8_LO;
                c.hi = BOUND_S8_HI;
            end
            FMT_UINT16:
            begin
                c.lo = BOUND_ZERO;
                c.hi = BOUND_U16_HI;
            end
            default:
            begin
                c.lo = BOUND_S16_LO;
                c.hi = BOUND_S16_HI;
            end
        endcase
        return c;
    endfunction

    // The magnitude must already be clipped to the mu-law limit.
    function automatic logic [7:0] mulaw_encode(logic sign, logic [14:0] mag);
        logic [15:0] m;
        logic [2:0]  seg;
        logic [3:0]  mant;
        m   = {1'b0, mag} + MULAW_BIAS;
        seg = 3'd0;
        for (int i = 0; i < 7; i++)
        begin
            if (m[i + 8])
            begin
                seg = 3'(i + 1);
            end
        end
        mant = 4'(m >> (4'(seg) + 4'd3));
        return ~{sign, seg, mant};
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/sample_requantizer_error_feedback_core.sv
// ----------------------------------------------------------------------------
// sample_requantizer_error_feedback_core
// Requantizes signed fixed-point samples to 8-bit, 16-bit or mu-law codes
// with first-order error feedback noise shaping on the 8- and 16-bit codes.
// ----------------------------------------------------------------------------
// Samples enter on the sample channel (sample_valid, sample_ready, sample_in)
// and each one gives exactly one result on the output channel (out_valid,
// out_ready, code_out, clipped). A transfer happens on a rising edge where
// valid and ready are both high.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready and should only be written while no sample is in flight.
// The datapath is a five-stage pipeline: offset add, magnitude, multiply,
// clamp, and the residual feedback stage that feeds the output register.
// One sample per cycle is sustained while the receiver is ready; the
// residual loop in the last stage, whose register each sample updates,
// sets that rate.
// When the receiver stalls, each stage keeps moving until it meets a full
// stage, so input is still taken until the pipeline is full.
// Reset empties the pipeline, clears the residual and loads the default
// format (int16), offset zero and unity gain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sample_requantizer_error_feedback_core #(
    parameter int FRAC_BITS = srq_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [srq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [srq_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                                 sample_valid,
    output logic                                      sample_ready,
    input  wire logic signed [srq_pkg::SAMPLE_W-1:0]  sample_in,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [srq_pkg::CODE_W-1:0]                code_out,
    output logic                                      clipped
);

    localparam int SUM_W  = srq_pkg::SAMPLE_W + 1;
    localparam int PROD_W = 64;
    localparam int Q_W    = PROD_W + 1 - FRAC_BITS;
    localparam int V_W    = Q_W + 1;
    localparam int XC_W   = srq_pkg::INT_W + FRAC_BITS;

    srq_pkg::fmt_t                    format_reg;
    logic [srq_pkg::CFG_DATA_W-1:0]   offset_reg;
    logic [srq_pkg::CFG_DATA_W-1:0]   gain_reg;
    srq_pkg::fmt_ctl_t                ctl;

    logic                             s0_valid_reg;
    logic signed [SUM_W-1:0]          s0_sum_reg;
    logic signed [SUM_W-1:0]          s0_sum_next;
    logic                             s1_valid_reg;
    logic                             s1_neg_reg;
    logic [SUM_W-1:0]                 s1_mag_reg;
    logic [SUM_W-1:0]                 s1_mag_next;
    logic                             s2_valid_reg;
    logic                             s2_neg_reg;
    logic [PROD_W-1:0]                s2_prod_reg;
    logic [PROD_W-1:0]                s2_prod_next;
    logic [PROD_W-1:0]                mul_lo;
    logic                             s3_valid_reg;
    logic signed [XC_W-1:0]           s3_xc_reg;
    logic signed [XC_W-1:0]           s3_xc_next;
    logic                             s3_clip_reg;
    logic                             s3_clip_next;
    logic                             out_valid_reg;
    logic                             clipped_reg;

    logic                             out_free;
    logic                             s3_free;
    logic                             s2_free;
    logic                             s1_free;
    logic                             s0_free;

    logic [PROD_W:0]                  prod_adj;
    logic [Q_W-1:0]                   q;
    logic signed [V_W-1:0]            v;
    logic signed [V_W-1:0]            lo_q;
    logic signed [V_W-1:0]            hi_q;
    logic signed [V_W-1:0]            xc_full;

    assign cfg_ready = 1'b1;
    assign ctl       = srq_pkg::fmt_decode(format_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= srq_pkg::FMT_RESET;
            offset_reg <= srq_pkg::OFFSET_RESET;
            gain_reg   <= srq_pkg::GAIN_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                srq_pkg::CFG_FORMAT: format_reg <= cfg_data[srq_pkg::MODE_W-1:0];
                srq_pkg::CFG_OFFSET: offset_reg <= cfg_data;
                srq_pkg::CFG_GAIN:   gain_reg   <= cfg_data;
                default:             ;
            endcase
        end
    end

    assign out_free     = !out_valid_reg || out_ready;
    assign s3_free      = !s3_valid_reg || out_free;
    assign s2_free      = !s2_valid_reg || s3_free;
    assign s1_free      = !s1_valid_reg || s2_free;
    assign s0_free      = !s0_valid_reg || s1_free;
    assign sample_ready = s0_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s0_free)
            begin
                s0_valid_reg <= sample_valid;
            end
            if (s1_free)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    assign s0_sum_next = {sample_in[srq_pkg::SAMPLE_W-1], sample_in}
                       + $signed({offset_reg[srq_pkg::CFG_DATA_W-1], offset_reg});

    assign s1_mag_next = s0_sum_reg[SUM_W-1] ? SUM_W'(-s0_sum_reg) : SUM_W'(s0_sum_reg);

    assign mul_lo       = {32'd0, s1_mag_reg[SUM_W-2:0]} * {32'd0, gain_reg};
    // A magnitude of exactly 2^32 has no low bits, so the product is a shift.
    assign s2_prod_next = s1_mag_reg[SUM_W-1] ? {gain_reg, 32'd0} : mul_lo;

    assign prod_adj = {1'b0, s2_prod_reg}
                    + (s2_neg_reg ? {{(PROD_W+1-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}}
                                  : {(PROD_W+1){1'b0}});
    assign q        = prod_adj[PROD_W:FRAC_BITS];
    assign v        = s2_neg_reg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    assign lo_q     = $signed({{(V_W-XC_W){ctl.lo[srq_pkg::INT_W-1]}}, ctl.lo,
                               {FRAC_BITS{1'b0}}});
    assign hi_q     = $signed({{(V_W-XC_W){ctl.hi[srq_pkg::INT_W-1]}}, ctl.hi,
                               {FRAC_BITS{1'b0}}});

    always_comb
    begin
        s3_clip_next = (v < lo_q) || (v > hi_q);
        if (v < lo_q)
        begin
            xc_full = lo_q;
        end
        else if (v > hi_q)
        begin
            xc_full = hi_q;
        end
        else
        begin
            xc_full = v;
        end
        s3_xc_next = xc_full[XC_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (s0_free && sample_valid)
        begin
            s0_sum_reg <= s0_sum_next;
        end
        if (s1_free && s0_valid_reg)
        begin
            s1_neg_reg <= s0_sum_reg[SUM_W-1];
            s1_mag_reg <= s1_mag_next;
        end
        if (s2_free && s1_valid_reg)
        begin
            s2_neg_reg  <= s1_neg_reg;
            s2_prod_reg <= s2_prod_next;
        end
        if (s3_free && s2_valid_reg)
        begin
            s3_xc_reg   <= s3_xc_next;
            s3_clip_reg <= s3_clip_next;
        end
        if (out_free && s3_valid_reg)
        begin
            clipped_reg <= s3_clip_reg;
        end
    end

    srq_shaper #(
        .FRAC_BITS (FRAC_BITS)
    ) u_shaper (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (out_free && s3_valid_reg),
        .xc    (s3_xc_reg),
        .ctl   (ctl),
        .code  (code_out)
    );

    assign out_valid = out_valid_reg;
    assign clipped   = clipped_reg;

endmodule

`default_nettype wire

// File: rtl/core/srq_shaper.sv
// ----------------------------------------------------------------------------
// srq_shaper
// Output stage: adds the stored residual, rounds half up, saturates and
// keeps the new residual; in mu-law mode it rounds and encodes instead.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srq_shaper #(
    parameter int FRAC_BITS = srq_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire logic                                         load,
    input  wire logic signed [srq_pkg::INT_W+FRAC_BITS-1:0]   xc,
    input  wire srq_pkg::fmt_ctl_t                            ctl,
    output logic [srq_pkg::CODE_W-1:0]                        code
);

    localparam int XC_W  = srq_pkg::INT_W + FRAC_BITS;
    localparam int T_W   = XC_W + 1;
    localparam int C_W   = T_W - FRAC_BITS;
    localparam int RES_W = FRAC_BITS + 2;

    localparam logic [T_W-1:0] HALF =
        {{(T_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

    logic signed [RES_W-1:0]          residual_reg;
    logic signed [RES_W-1:0]          residual_next;
    logic [srq_pkg::CODE_W-1:0]       code_reg;
    logic [srq_pkg::CODE_W-1:0]       code_next;

    logic signed [T_W-1:0]            t;
    logic signed [T_W-1:0]            tr;
    logic signed [C_W-1:0]            c_full;
    logic signed [C_W-1:0]            lo_c;
    logic signed [C_W-1:0]            hi_c;
    logic signed [C_W-1:0]            code_c;
    logic signed [T_W-1:0]            res_full;

    logic signed [T_W-1:0]            tm;
    logic signed [C_W-1:0]            cm;
    logic                             mu_sign;
    logic [C_W-1:0]                   cmag;
    logic [14:0]                      mu_mag;
    logic [7:0]                       mu_byte;

    assign t      = {xc[XC_W-1], xc}
                  + {{(T_W-RES_W){residual_reg[RES_W-1]}}, residual_reg};
    assign tr     = t + $signed(HALF);
    assign c_full = tr[T_W-1:FRAC_BITS];
    assign lo_c   = {ctl.lo[srq_pkg::INT_W-1], ctl.lo};
    assign hi_c   = {ctl.hi[srq_pkg::INT_W-1], ctl.hi};

    always_comb
    begin
        if (c_full < lo_c)
        begin
            code_c = lo_c;
        end
        else if (c_full > hi_c)
        begin
            code_c = hi_c;
        end
        else
        begin
            code_c = c_full;
        end
    end

    assign res_full      = t - {code_c, {FRAC_BITS{1'b0}}};
    assign residual_next = res_full[RES_W-1:0];

    assign tm      = {xc[XC_W-1], xc} + $signed(HALF);
    assign cm      = tm[T_W-1:FRAC_BITS];
    assign mu_sign = cm[C_W-1];
    assign cmag    = mu_sign ? C_W'(-cm) : C_W'(cm);
    assign mu_mag  = (cmag > C_W'(srq_pkg::MULAW_CLIP)) ? srq_pkg::MULAW_CLIP : cmag[14:0];
    assign mu_byte = srq_pkg::mulaw_encode(mu_sign, mu_mag);

    always_comb
    begin
        if (ctl.mulaw)
        begin
            code_next = {8'd0, mu_byte};
        end
        else if (ctl.narrow)
        begin
            code_next = {8'd0, code_c[7:0]};
        end
        else
        begin
            code_next = code_c[srq_pkg::CODE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            residual_reg <= '0;
        end
        else if (load && !ctl.mulaw)
        begin
            residual_reg <= residual_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            code_reg <= code_next;
        end
    end

    assign code = code_reg;

endmodule

`default_nettype wire

// File: rtl/core/srq_checker.sv
// ----------------------------------------------------------------------------
// srq_checker
// Port-level checks of the requantizer core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srq_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 cfg_valid,
    input wire logic                                 cfg_ready,
    input wire logic [srq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input wire logic [srq_pkg::CFG_DATA_W-1:0]       cfg_data,
    input wire logic                                 sample_valid,
    input wire logic                                 sample_ready,
    input wire logic                                 out_valid,
    input wire logic                                 out_ready,
    input wire logic [srq_pkg::CODE_W-1:0]           code_out,
    input wire logic                                 clipped
);

    srq_pkg::fmt_t mode_reg;
    logic          in_xfer;
    logic          byte_mode;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= srq_pkg::FMT_RESET;
        end
        else if (cfg_valid && cfg_ready && (cfg_index == srq_pkg::CFG_FORMAT))
        begin
            mode_reg <= cfg_data[srq_pkg::MODE_W-1:0];
        end
    end

    assign in_xfer   = sample_valid && sample_ready;
    assign byte_mode = (mode_reg == srq_pkg::FMT_UINT8) || (mode_reg == srq_pkg::FMT_INT8)
                    || (mode_reg == srq_pkg::FMT_MULAW);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code_out) && $stable(clipped))
        else $error("result changed while stalled");

    // With the receiver ready throughout, a transferred sample comes out after passing every stage.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(in_xfer, 5) && $past(rst_n, 5) && $past(rst_n, 4) && $past(rst_n, 3)
        && $past(rst_n, 2) && $past(rst_n, 1) && $past(out_ready, 4)
        && $past(out_ready, 3) && $past(out_ready, 2) && $past(out_ready, 1)
        |-> out_valid)
        else $error("result missing after pipeline latency");

    // Byte formats leave the upper code bits clear.
    a_byte_upper: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_mode |-> code_out[15:8] == 8'd0)
        else $error("upper code bits set in a byte format");

    // A clamped int16 value always lands on a range limit despite the feedback.
    a_int16_clip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped && (mode_reg == srq_pkg::FMT_INT16)
        |-> (code_out == 16'h8000) || (code_out == 16'h7FFF))
        else $error("clipped int16 code is not a range limit");

endmodule

bind sample_requantizer_error_feedback_core srq_checker u_srq_checker (.*);

`default_nettype wire
